// ----- rtl/sm4_pkg.sv -----
// Shared types, constants and helper functions for the SM4 block cipher.
`timescale 1ns / 1ps
`default_nettype none

package sm4_pkg;

  // Round geometry
  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned CNT_W       = $clog2(ROUND_COUNT);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_WORDS   = 4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = CFG_IDX_W'(3);

  // Action codes carried with each item
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // System parameter FK
  localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
  localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
  localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
  localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_WORDS-1:0] block_t;

  // Which linear transform the round unit applies
  typedef enum logic {
    RND_KEY  = 1'b0,
    RND_DATA = 1'b1
  } rnd_mode_e;

  // Round key store write request
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    word_t            data;
  } rk_wr_t;

  // Left rotate by a constant amount
  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  // SM4 S-box
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] y;
    case (x)
      8'h00: y = 8'hD6; 8'h01: y = 8'h90; 8'h02: y = 8'hE9; 8'h03: y = 8'hFE;
      8'h04: y = 8'hCC; 8'h05: y = 8'hE1; 8'h06: y = 8'h3D; 8'h07: y = 8'hB7;
      8'h08: y = 8'h16; 8'h09: y = 8'hB6; 8'h0A: y = 8'h14; 8'h0B: y = 8'hC2;
      8'h0C: y = 8'h28; 8'h0D: y = 8'hFB; 8'h0E: y = 8'h2C; 8'h0F: y = 8'h05;
      8'h10: y = 8'h2B; 8'h11: y = 8'h67; 8'h12: y = 8'h9A; 8'h13: y = 8'h76;
      8'h14: y = 8'h2A; 8'h15: y = 8'hBE; 8'h16: y = 8'h04; 8'h17: y = 8'hC3;
      8'h18: y = 8'hAA; 8'h19: y = 8'h44; 8'h1A: y = 8'h13; 8'h1B: y = 8'h26;
      8'h1C: y = 8'h49; 8'h1D: y = 8'h86; 8'h1E: y = 8'h06; 8'h1F: y = 8'h99;
      8'h20: y = 8'h9C; 8'h21: y = 8'h42; 8'h22: y = 8'h50; 8'h23: y = 8'hF4;
      8'h24: y = 8'h91; 8'h25: y = 8'hEF; 8'h26: y = 8'h98; 8'h27: y = 8'h7A;
      8'h28: y = 8'h33; 8'h29: y = 8'h54; 8'h2A: y = 8'h0B; 8'h2B: y = 8'h43;
      8'h2C: y = 8'hED; 8'h2D: y = 8'hCF; 8'h2E: y = 8'hAC; 8'h2F: y = 8'h62;
      8'h30: y = 8'hE4; 8'h31: y = 8'hB3; 8'h32: y = 8'h1C; 8'h33: y = 8'hA9;
      8'h34: y = 8'hC9; 8'h35: y = 8'h08; 8'h36: y = 8'hE8; 8'h37: y = 8'h95;
      8'h38: y = 8'h80; 8'h39: y = 8'hDF; 8'h3A: y = 8'h94; 8'h3B: y = 8'hFA;
      8'h3C: y = 8'h75; 8'h3D: y = 8'h8F; 8'h3E: y = 8'h3F; 8'h3F: y = 8'hA6;
      8'h40: y = 8'h47; 8'h41: y = 8'h07; 8'h42: y = 8'hA7; 8'h43: y = 8'hFC;
      8'h44: y = 8'hF3; 8'h45: y = 8'h73; 8'h46: y = 8'h17; 8'h47: y = 8'hBA;
      8'h48: y = 8'h83; 8'h49: y = 8'h59; 8'h4A: y = 8'h3C; 8'h4B: y = 8'h19;
      8'h4C: y = 8'hE6; 8'h4D: y = 8'h85; 8'h4E: y = 8'h4F; 8'h4F: y = 8'hA8;
      8'h50: y = 8'h68; 8'h51: y = 8'h6B; 8'h52: y = 8'h81; 8'h53: y = 8'hB2;
      8'h54: y = 8'h71; 8'h55: y = 8'h64; 8'h56: y = 8'hDA; 8'h57: y = 8'h8B;
      8'h58: y = 8'hF8; 8'h59: y = 8'hEB; 8'h5A: y = 8'h0F; 8'h5B: y = 8'h4B;
      8'h5C: y = 8'h70; 8'h5D: y = 8'h56; 8'h5E: y = 8'h9D; 8'h5F: y = 8'h35;
      8'h60: y = 8'h1E; 8'h61: y = 8'h24; 8'h62: y = 8'h0E; 8'h63: y = 8'h5E;
      8'h64: y = 8'h63; 8'h65: y = 8'h58; 8'h66: y = 8'hD1; 8'h67: y = 8'hA2;
      8'h68: y = 8'h25; 8'h69: y = 8'h22; 8'h6A: y = 8'h7C; 8'h6B: y = 8'h3B;
      8'h6C: y = 8'h01; 8'h6D: y = 8'h21; 8'h6E: y = 8'h78; 8'h6F: y = 8'h87;
      8'h70: y = 8'hD4; 8'h71: y = 8'h00; 8'h72: y = 8'h46; 8'h73: y = 8'h57;
      8'h74: y = 8'h9F; 8'h75: y = 8'hD3; 8'h76: y = 8'h27; 8'h77: y = 8'h52;
      8'h78: y = 8'h4C; 8'h79: y = 8'h36; 8'h7A: y = 8'h02; 8'h7B: y = 8'hE7;
      8'h7C: y = 8'hA0; 8'h7D: y = 8'hC4; 8'h7E: y = 8'hC8; 8'h7F: y = 8'h9E;
      8'h80: y = 8'hEA; 8'h81: y = 8'hBF; 8'h82: y = 8'h8A; 8'h83: y = 8'hD2;
      8'h84: y = 8'h40; 8'h85: y = 8'hC7; 8'h86: y = 8'h38; 8'h87: y = 8'hB5;
      8'h88: y = 8'hA3; 8'h89: y = 8'hF7; 8'h8A: y = 8'hF2; 8'h8B: y = 8'hCE;
      8'h8C: y = 8'hF9; 8'h8D: y = 8'h61; 8'h8E: y = 8'h15; 8'h8F: y = 8'hA1;
      8'h90: y = 8'hE0; 8'h91: y = 8'hAE; 8'h92: y = 8'h5D; 8'h93: y = 8'hA4;
      8'h94: y = 8'h9B; 8'h95: y = 8'h34; 8'h96: y = 8'h1A; 8'h97: y = 8'h55;
      8'h98: y = 8'hAD; 8'h99: y = 8'h93; 8'h9A: y = 8'h32; 8'h9B: y = 8'h30;
      8'h9C: y = 8'hF5; 8'h9D: y = 8'h8C; 8'h9E: y = 8'hB1; 8'h9F: y = 8'hE3;
      8'hA0: y = 8'h1D; 8'hA1: y = 8'hF6; 8'hA2: y = 8'hE2; 8'hA3: y = 8'h2E;
      8'hA4: y = 8'h82; 8'hA5: y = 8'h66; 8'hA6: y = 8'hCA; 8'hA7: y = 8'h60;
      8'hA8: y = 8'hC0; 8'hA9: y = 8'h29; 8'hAA: y = 8'h23; 8'hAB: y = 8'hAB;
      8'hAC: y = 8'h0D; 8'hAD: y = 8'h53; 8'hAE: y = 8'h4E; 8'hAF: y = 8'h6F;
      8'hB0: y = 8'hD5; 8'hB1: y = 8'hDB; 8'hB2: y = 8'h37; 8'hB3: y = 8'h45;
      8'hB4: y = 8'hDE; 8'hB5: y = 8'hFD; 8'hB6: y = 8'h8E; 8'hB7: y = 8'h2F;
      8'hB8: y = 8'h03; 8'hB9: y = 8'hFF; 8'hBA: y = 8'h6A; 8'hBB: y = 8'h72;
      8'hBC: y = 8'h6D; 8'hBD: y = 8'h6C; 8'hBE: y = 8'h5B; 8'hBF: y = 8'h51;
      8'hC0: y = 8'h8D; 8'hC1: y = 8'h1B; 8'hC2: y = 8'hAF; 8'hC3: y = 8'h92;
      8'hC4: y = 8'hBB; 8'hC5: y = 8'hDD; 8'hC6: y = 8'hBC; 8'hC7: y = 8'h7F;
      8'hC8: y = 8'h11; 8'hC9: y = 8'hD9; 8'hCA: y = 8'h5C; 8'hCB: y = 8'h41;
      8'hCC: y = 8'h1F; 8'hCD: y = 8'h10; 8'hCE: y = 8'h5A; 8'hCF: y = 8'hD8;
      8'hD0: y = 8'h0A; 8'hD1: y = 8'hC1; 8'hD2: y = 8'h31; 8'hD3: y = 8'h88;
      8'hD4: y = 8'hA5; 8'hD5: y = 8'hCD; 8'hD6: y = 8'h7B; 8'hD7: y = 8'hBD;
      8'hD8: y = 8'h2D; 8'hD9: y = 8'h74; 8'hDA: y = 8'hD0; 8'hDB: y = 8'h12;
      8'hDC: y = 8'hB8; 8'hDD: y = 8'hE5; 8'hDE: y = 8'hB4; 8'hDF: y = 8'hB0;
      8'hE0: y = 8'h89; 8'hE1: y = 8'h69; 8'hE2: y = 8'h97; 8'hE3: y = 8'h4A;
      8'hE4: y = 8'h0C; 8'hE5: y = 8'h96; 8'hE6: y = 8'h77; 8'hE7: y = 8'h7E;
      8'hE8: y = 8'h65; 8'hE9: y = 8'hB9; 8'hEA: y = 8'hF1; 8'hEB: y = 8'h09;
      8'hEC: y = 8'hC5; 8'hED: y = 8'h6E; 8'hEE: y = 8'hC6; 8'hEF: y = 8'h84;
      8'hF0: y = 8'h18; 8'hF1: y = 8'hF0; 8'hF2: y = 8'h7D; 8'hF3: y = 8'hEC;
      8'hF4: y = 8'h3A; 8'hF5: y = 8'hDC; 8'hF6: y = 8'h4D; 8'hF7: y = 8'h20;
      8'hF8: y = 8'h79; 8'hF9: y = 8'hEE; 8'hFA: y = 8'h5F; 8'hFB: y = 8'h3E;
      8'hFC: y = 8'hD7; 8'hFD: y = 8'hCB; 8'hFE: y = 8'h39; 8'hFF: y = 8'h48;
      default: y = 8'h00;
    endcase
    sbox = y;
  endfunction

  // Four parallel S-boxes over one word
  function automatic word_t tau(input word_t x);
    tau = {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

  // CK constant: byte j of round i is (28*i + 7*j) mod 256
  function automatic word_t ck_word(input logic [CNT_W-1:0] i);
    logic [7:0] base;
    base = 8'(i) * 8'd28;
    ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
  endfunction

  // Round key index for round i under the given action
  function automatic logic [CNT_W-1:0] rk_index(input logic [CNT_W-1:0] i,
                                                 input logic act);
    rk_index = (act == ACT_DECRYPT) ? (CNT_W'(ROUND_COUNT - 1) - i) : i;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sm4_round.sv -----
// Shared SM4 round unit: one key-schedule or cipher round per use.
`timescale 1ns / 1ps
`default_nettype none

module sm4_round (
  input  wire  sm4_pkg::block_t    words_i,
  input  wire  sm4_pkg::word_t     tweak_i,
  input  wire  sm4_pkg::rnd_mode_e mode_i,
  output logic [31:0]              next_word_o
);
  import sm4_pkg::*;

  word_t mix;
  word_t sub;
  word_t lin;

  // Combine the three newest words with the round constant or round key, then substitute
  assign mix = words_i[1] ^ words_i[2] ^ words_i[3] ^ tweak_i;
  assign sub = tau(mix);

  // Pick the cipher transform L or the key schedule transform L'
  always_comb begin
    if (mode_i == RND_DATA) begin
      lin = sub ^ rotl(sub, 2) ^ rotl(sub, 10) ^ rotl(sub, 18) ^ rotl(sub, 24);
    end else begin
      lin = sub ^ rotl(sub, 13) ^ rotl(sub, 23);
    end
  end

  assign next_word_o = words_i[0] ^ lin;

endmodule

`default_nettype wire

// ----- rtl/sm4_key_ram.sv -----
// Round key store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sm4_key_ram (
  input  wire                             clk_i,
  input  wire  sm4_pkg::rk_wr_t           wr_i,
  input  wire  [sm4_pkg::CNT_W-1:0]       rd_addr_i,
  output logic [31:0]                     rd_data_o
);
  import sm4_pkg::*;

  word_t mem_q [ROUND_COUNT];
  word_t rd_data_q;

  // Write one round key during expansion
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Register the read data for the next round
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/sm4_block_cipher.sv -----
// Top level of the SM4 block cipher: sequencer, key registers and result register.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  action_i, data_word0_i..data_word3_i
// out       output     out_valid_o/out_ready_i result_word0_o..result_word3_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is accepted and then runs 32 rounds through the shared round unit.
// After a key write the next item first expands the round keys through the same
// unit and then reloads its data before its rounds.
// The input stays not ready from accept until the result is in the output
// register; a stalled output holds the finished block in a wait state.
// Key writes are taken only while idle, and a pending write holds off the input.
// Reset clears the key registers and marks the round keys stale.
`timescale 1ns / 1ps
`default_nettype none

module sm4_block_cipher (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input item channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         action_i,
  input  wire  [31:0] data_word0_i,
  input  wire  [31:0] data_word1_i,
  input  wire  [31:0] data_word2_i,
  input  wire  [31:0] data_word3_i,
  // Result item channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] result_word0_o,
  output logic [31:0] result_word1_o,
  output logic [31:0] result_word2_o,
  output logic [31:0] result_word3_o,
  // Configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [sm4_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import sm4_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             keys_ready_q, keys_ready_d;
  logic             action_q, action_d;
  block_t           sh_q, sh_d;
  block_t           data_q, data_d;
  word_t            key_q [KEY_WORDS];
  block_t           res_q, res_d;
  logic             out_valid_q, out_valid_d;

  logic             in_fire;
  logic             cfg_fire;
  logic             cfg_hit;
  logic             out_free;
  logic             cnt_last;
  rnd_mode_e        rnd_mode;
  word_t            tweak;
  word_t            next_word;
  word_t            rk_data;
  rk_wr_t           rk_wr;
  logic [CNT_W-1:0] rd_addr;

  // Take key writes only while idle; a pending write goes before an item
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_fire && (cfg_index_i <= REG_KEY_WORD3);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cnt_last    = (cnt_q == CNT_W'(ROUND_COUNT - 1));

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_WORDS; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_hit) begin
      key_q[cfg_index_i[1:0] - REG_KEY_WORD0[1:0]] <= cfg_data_i;
    end
  end

  // Round unit operand selection
  assign rnd_mode = (state_q == ST_EXPAND) ? RND_KEY : RND_DATA;
  assign tweak    = (state_q == ST_EXPAND) ? ck_word(cnt_q) : rk_data;

  sm4_round u_round (
    .words_i     (sh_q),
    .tweak_i     (tweak),
    .mode_i      (rnd_mode),
    .next_word_o (next_word)
  );

  // Store each expanded key at its round index
  always_comb begin
    rk_wr.en   = (state_q == ST_EXPAND);
    rk_wr.addr = cnt_q;
    rk_wr.data = next_word;
  end

  // Prefetch the round key for the coming round
  always_comb begin
    unique case (state_q)
      ST_IDLE:  rd_addr = rk_index('0, action_i);
      ST_LOAD:  rd_addr = rk_index('0, action_q);
      ST_ROUND: rd_addr = rk_index(cnt_q + CNT_W'(1), action_q);
      default:  rd_addr = '0;
    endcase
  end

  sm4_key_ram u_key_ram (
    .clk_i     (clk_i),
    .wr_i      (rk_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rk_data)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    action_d     = action_q;
    sh_d         = sh_q;
    data_d       = data_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          action_d = action_i;
          cnt_d    = '0;
          if (keys_ready_q) begin
            sh_d    = {data_word3_i, data_word2_i, data_word1_i, data_word0_i};
            state_d = ST_ROUND;
          end else begin
            data_d  = {data_word3_i, data_word2_i, data_word1_i, data_word0_i};
            sh_d    = {key_q[3] ^ FK3, key_q[2] ^ FK2, key_q[1] ^ FK1, key_q[0] ^ FK0};
            state_d = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        sh_d  = {next_word, sh_q[3], sh_q[2], sh_q[1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last) begin
          keys_ready_d = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        sh_d    = data_q;
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        sh_d  = {next_word, sh_q[3], sh_q[2], sh_q[1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last) begin
          if (out_free) begin
            res_d       = {sh_q[1], sh_q[2], sh_q[3], next_word};
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_d       = {sh_q[0], sh_q[1], sh_q[2], sh_q[3]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Drop the expanded keys on any key write
    if (cfg_hit) begin
      keys_ready_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    sh_q     <= sh_d;
    data_q   <= data_d;
    res_q    <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_word0_o = res_q[0];
  assign result_word1_o = res_q[1];
  assign result_word2_o = res_q[2];
  assign result_word3_o = res_q[3];

  // Cipher rounds only run on an expanded key schedule
  a_round_keys_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> keys_ready_q)
    else $error("cipher round with stale round keys");

  // Expansion only runs while the keys are stale
  a_expand_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPAND) |-> !keys_ready_q)
    else $error("key expansion with keys already ready");

  // An item on stale keys starts with expansion
  a_stale_expands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !keys_ready_q) |=> (state_q == ST_EXPAND))
    else $error("stale keys not expanded before rounds");

  // The wait state is only held while a result blocks the output register
  a_done_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> out_valid_q)
    else $error("waiting on a free output register");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

endmodule

`default_nettype wire

// ----- bench/sm4_cipher_checker.sv -----
// Result checker for the SM4 block cipher: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module sm4_cipher_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input item channel
  input  wire                          in_valid_i,
  input  wire                          in_ready_i,
  input  wire                          action_i,
  input  wire  [31:0]                  data_word0_i,
  input  wire  [31:0]                  data_word1_i,
  input  wire  [31:0]                  data_word2_i,
  input  wire  [31:0]                  data_word3_i,
  // Result item channel
  input  wire                          out_valid_i,
  input  wire                          out_ready_i,
  input  wire  [31:0]                  result_word0_i,
  input  wire  [31:0]                  result_word1_i,
  input  wire  [31:0]                  result_word2_i,
  input  wire  [31:0]                  result_word3_i,
  // Configuration write channel
  input  wire                          cfg_valid_i,
  input  wire                          cfg_ready_i,
  input  wire  [sm4_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [31:0]                  cfg_data_i,
  // Status toward the stimulus side
  output int                           mismatch_count_o,
  output int                           pending_count_o
);
  import sm4_pkg::*;

  // Byte substitution table, entry 0 in the top byte
  localparam logic [2047:0] SUBST_BITS = {
    32'hD690E9FE, 32'hCCE13DB7, 32'h16B614C2, 32'h28FB2C05,
    32'h2B679A76, 32'h2ABE04C3, 32'hAA441326, 32'h49860699,
    32'h9C4250F4, 32'h91EF987A, 32'h33540B43, 32'hEDCFAC62,
    32'hE4B31CA9, 32'hC908E895, 32'h80DF94FA, 32'h758F3FA6,
    32'h4707A7FC, 32'hF37317BA, 32'h83593C19, 32'hE6854FA8,
    32'h686B81B2, 32'h7164DA8B, 32'hF8EB0F4B, 32'h70569D35,
    32'h1E240E5E, 32'h6358D1A2, 32'h25227C3B, 32'h01217887,
    32'hD4004657, 32'h9FD32752, 32'h4C3602E7, 32'hA0C4C89E,
    32'hEABF8AD2, 32'h40C738B5, 32'hA3F7F2CE, 32'hF96115A1,
    32'hE0AE5DA4, 32'h9B341A55, 32'hAD933230, 32'hF58CB1E3,
    32'h1DF6E22E, 32'h8266CA60, 32'hC02923AB, 32'h0D534E6F,
    32'hD5DB3745, 32'hDEFD8E2F, 32'h03FF6A72, 32'h6D6C5B51,
    32'h8D1BAF92, 32'hBBDDBC7F, 32'h11D95C41, 32'h1F105AD8,
    32'h0AC13188, 32'hA5CD7BBD, 32'h2D74D012, 32'hB8E5B4B0,
    32'h8969974A, 32'h0C96777E, 32'h65B9F109, 32'hC56EC684,
    32'h18F07DEC, 32'h3ADC4D20, 32'h79EE5F3E, 32'hD7CB3948
  };

  localparam int REPORT_LIMIT = 10;

  // Output block, most significant word first
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
  } cipher_block_t;

  word_t         key_words [KEY_WORDS];
  word_t         round_keys [ROUND_COUNT];
  logic          keys_stale;
  cipher_block_t expected_blocks [$];
  cipher_block_t want;

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  // Substitute each byte of a word
  function automatic word_t sub_word(input word_t x);
    word_t y;
    int    idx;
    for (int b = 0; b < 4; b++) begin
      idx           = x[8*b +: 8];
      y[8*b +: 8]   = SUBST_BITS[2047 - 8*idx -: 8];
    end
    return y;
  endfunction

  function automatic word_t rot_l(input word_t x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  // Linear mix of the data rounds
  function automatic word_t round_mix(input word_t b);
    return b ^ rot_l(b, 2) ^ rot_l(b, 10) ^ rot_l(b, 18) ^ rot_l(b, 24);
  endfunction

  // Linear mix of the key schedule
  function automatic word_t key_mix(input word_t b);
    return b ^ rot_l(b, 13) ^ rot_l(b, 23);
  endfunction

  // Schedule constant: byte j of step i is 28*i + 7*j modulo 256
  function automatic word_t sched_const(input int i);
    word_t c;
    c = '0;
    for (int j = 0; j < 4; j++) c = {c[23:0], 8'(28 * i + 7 * j)};
    return c;
  endfunction

  // Rebuild the round keys from the current key words
  task automatic expand_round_keys();
    word_t k0, k1, k2, k3, nk;
    k0 = key_words[0] ^ FK0;
    k1 = key_words[1] ^ FK1;
    k2 = key_words[2] ^ FK2;
    k3 = key_words[3] ^ FK3;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      nk            = k0 ^ key_mix(sub_word(k1 ^ k2 ^ k3 ^ sched_const(i)));
      k0            = k1;
      k1            = k2;
      k2            = k3;
      k3            = nk;
      round_keys[i] = nk;
    end
    keys_stale = 1'b0;
  endtask

  // Run all rounds over one block; decryption walks the keys backward
  function automatic cipher_block_t run_rounds(input logic act, input word_t d0,
                                               input word_t d1, input word_t d2,
                                               input word_t d3);
    cipher_block_t r;
    word_t         x0, x1, x2, x3, nx, rk;
    x0 = d0;
    x1 = d1;
    x2 = d2;
    x3 = d3;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      rk = (act == ACT_DECRYPT) ? round_keys[ROUND_COUNT - 1 - i] : round_keys[i];
      nx = x0 ^ round_mix(sub_word(x1 ^ x2 ^ x3 ^ rk));
      x0 = x1;
      x1 = x2;
      x2 = x3;
      x3 = nx;
    end
    r.w0 = x3;
    r.w1 = x2;
    r.w2 = x1;
    r.w3 = x0;
    return r;
  endfunction

  task automatic report(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_word(input string name, input word_t exp_w, input word_t got_w);
    if (got_w !== exp_w) begin
      report($sformatf("%s expected %08h got %08h", name, exp_w, got_w));
    end
  endtask

  // Compare finished items, track key writes, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_blocks.delete();
      for (int i = 0; i < KEY_WORDS; i++) key_words[i] = '0;
      keys_stale      = 1'b1;
      pending_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          report($sformatf("unexpected result %08h %08h %08h %08h", result_word0_i,
                           result_word1_i, result_word2_i, result_word3_i));
        end else begin
          want = expected_blocks.pop_front();
          check_word("result_word0", want.w0, result_word0_i);
          check_word("result_word1", want.w1, result_word1_i);
          check_word("result_word2", want.w2, result_word2_i);
          check_word("result_word3", want.w3, result_word3_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= REG_KEY_WORD3) begin
        key_words[int'(cfg_index_i - REG_KEY_WORD0)] = cfg_data_i;
        keys_stale = 1'b1;
      end
      if (in_valid_i && in_ready_i) begin
        if (keys_stale) expand_round_keys();
        expected_blocks.push_back(run_rounds(action_i, data_word0_i, data_word1_i,
                                             data_word2_i, data_word3_i));
      end
      pending_count_o = expected_blocks.size();
    end
  end

endmodule

// ----- bench/sm4_block_cipher_test.sv -----
// Testbench top for the SM4 block cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sm4_block_cipher_test;
  import sm4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1    = CFG_IDX_W'(REG_KEY_WORD0 + 1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2    = CFG_IDX_W'(REG_KEY_WORD0 + 2);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_KEY_WORD3 + 1);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;
  localparam int RANDOM_ITEMS = 900;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 80;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 action    = ACT_ENCRYPT;
  word_t                data_w0   = '0;
  word_t                data_w1   = '0;
  word_t                data_w2   = '0;
  word_t                data_w3   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  word_t                result_w0;
  word_t                result_w1;
  word_t                result_w2;
  word_t                result_w3;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_WORD0;
  word_t                cfg_data  = '0;

  int    mismatches;
  int    pending;
  int    burst_left = 0;
  bit    gaps_on    = 1'b1;
  int    hold_left  = 0;
  word_t key_shadow [KEY_WORDS];

  sm4_block_cipher u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .data_word0_i   (data_w0),
    .data_word1_i   (data_w1),
    .data_word2_i   (data_w2),
    .data_word3_i   (data_w3),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_word0_o (result_w0),
    .result_word1_o (result_w1),
    .result_word2_o (result_w2),
    .result_word3_o (result_w3),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  sm4_cipher_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .data_word0_i     (data_w0),
    .data_word1_i     (data_w1),
    .data_word2_i     (data_w2),
    .data_word3_i     (data_w3),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .result_word0_i   (result_w0),
    .result_word1_i   (result_w1),
    .result_word2_i   (result_w2),
    .result_word3_i   (result_w3),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always #1 clk = ~clk;

  // Alternate ready spans and stall spans on the result side
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      hold_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                               : $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
      hold_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(200, 500)
                                               : $urandom_range(0, 40);
    end
  end

  // Mostly random words, with the extremes now and then
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold it until accepted; open a new burst when due
  task automatic send_item(input logic act, input word_t d0, input word_t d1,
                           input word_t d2, input word_t d3);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = !gaps_on ? 0 : ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                        : $urandom_range(0, 12);
      if (gap != 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= act;
    data_w0  <= d0;
    data_w1  <= d1;
    data_w2  <= d2;
    data_w3  <= d3;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_item();
    send_item($urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT,
              pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  // Drop valid and hold until every item has come back
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_KEY_WORD3) key_shadow[int'(idx - REG_KEY_WORD0)] = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    wait_idle();
    write_register(REG_KEY_WORD0, k0);
    write_register(REG_KEY_WORD1, k1);
    write_register(REG_KEY_WORD2, k2);
    write_register(REG_KEY_WORD3, k3);
  endtask

  // Main stimulus
  initial begin
    int random_items;
    int n;
    int guard;
    random_items = 0;
    for (int i = 0; i < KEY_WORDS; i++) key_shadow[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset key, never written
    send_item(ACT_ENCRYPT, '0, '0, '0, '0);
    send_item(ACT_DECRYPT, '0, '0, '0, '0);
    send_item(ACT_ENCRYPT, '1, '1, '1, '1);

    // Standard key and block, both directions
    load_key(32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210);
    send_item(ACT_ENCRYPT, 32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210);
    send_item(ACT_DECRYPT, 32'h681EDF34, 32'hD206965E, 32'h86B3E94F, 32'h536E4246);
    send_item(ACT_ENCRYPT, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);

    // All-ones key
    load_key('1, '1, '1, '1);
    send_item(ACT_ENCRYPT, '1, '1, '1, '1);
    send_item(ACT_DECRYPT, '1, '1, '1, '1);
    send_item(ACT_ENCRYPT, '0, '0, '0, '0);

    // All-zero key written explicitly
    load_key('0, '0, '0, '0);
    send_item(ACT_ENCRYPT, '1, '1, '1, '1);
    send_item(ACT_DECRYPT, '0, '0, '0, '0);

    // Same value rewritten still forces a fresh expansion
    load_key(32'h0F1E2D3C, 32'h4B5A6978, 32'h8796A5B4, 32'hC3D2E1F0);
    send_item(ACT_ENCRYPT, 32'hDEADBEEF, 32'h01020304, 32'hCAFEF00D, 32'h80000001);
    wait_idle();
    write_register(REG_KEY_WORD1, key_shadow[1]);
    send_item(ACT_DECRYPT, 32'hDEADBEEF, 32'h01020304, 32'hCAFEF00D, 32'h80000001);

    // Writes past the key registers leave the keys alone
    wait_idle();
    write_register(REG_FIRST_UNUSED, '1);
    send_item(ACT_ENCRYPT, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFE);
    wait_idle();
    write_register(REG_LAST_UNUSED, 32'h12345678);
    send_item(ACT_DECRYPT, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFE);

    // A single key word changed
    wait_idle();
    write_register(REG_KEY_WORD2, $urandom);
    send_item(ACT_ENCRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    send_item(ACT_DECRYPT, pick_word(), pick_word(), pick_word(), pick_word());

    // Back-to-back burst
    gaps_on    = 1'b0;
    burst_left = 0;
    repeat (4) send_random_item();

    // Random phases: optional rekey, then a run of items
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 6))
        0: ;
        1: write_register(CFG_IDX_W'(REG_KEY_WORD0 + $urandom_range(0, 3)), pick_word());
        2: load_key($urandom, $urandom, $urandom, $urandom);
        3: load_key($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0,
                    $urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0);
        4: begin
          n = $urandom_range(0, 3);
          write_register(CFG_IDX_W'(REG_KEY_WORD0 + n), key_shadow[n]);
        end
        5: write_register(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                          $urandom);
        default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      repeat (n) begin
        send_random_item();
        random_items++;
      end
    end

    // Drain and settle
    @(negedge clk) in_valid <= 1'b0;
    for (guard = 0; pending != 0 && guard < DRAIN_LIMIT; guard++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("sm4_block_cipher test passed");
    end else begin
      $display("sm4_block_cipher test failed");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("sm4_block_cipher test failed");
    $finish;
  end

endmodule
